// ===== rtl/bcu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the barometer compensation unit.
// ----------------------------------------------------------------------------
package bcu_pkg;

	localparam int unsigned OSS_W   = 2;
	localparam int unsigned CGA_W   = 64;
	localparam int unsigned CGB_W   = 64;
	localparam int unsigned CGC_W   = 48;
	localparam int unsigned CFG_W   = 64;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned RAW_W   = 24;
	localparam int unsigned TEMP_W  = 16;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned CNT_W   = 5;

	localparam logic [IDX_W-1:0] REG_OSS = 2'd0;
	localparam logic [IDX_W-1:0] REG_CGA = 2'd1;
	localparam logic [IDX_W-1:0] REG_CGB = 2'd2;
	localparam logic [IDX_W-1:0] REG_CGC = 2'd3;

	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	localparam logic [31:0] PRESS_OFFSET_T = 32'd4000;
	localparam logic [15:0] PRESS_SCALE    = 16'd50000;
	localparam logic [31:0] PRESS_BIAS     = 32'd32768;
	localparam logic [31:0] CORR_A         = 32'd3038;
	localparam logic [31:0] CORR_B         = 32'hFFFF_E343; // -7357
	localparam logic [31:0] CORR_C         = 32'd3791;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CALC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef enum logic [4:0] {
		SP_T_MUL   = 5'd0,
		SP_T_X1    = 5'd1,
		SP_T_DIV   = 5'd2,
		SP_B5      = 5'd3,
		SP_B6SQ    = 5'd4,
		SP_SQ      = 5'd5,
		SP_AC2     = 5'd6,
		SP_X3A     = 5'd7,
		SP_B3      = 5'd8,
		SP_X3B     = 5'd9,
		SP_B4MUL   = 5'd10,
		SP_B4      = 5'd11,
		SP_P_DIV   = 5'd12,
		SP_P       = 5'd13,
		SP_PSQ     = 5'd14,
		SP_CA      = 5'd15,
		SP_CB      = 5'd16,
		SP_RES     = 5'd17
	} step_t;

endpackage

// ===== rtl/bcu_req_if.sv =====
// ----------------------------------------------------------------------------
// bcu_req_if
// Raw sample channel: valid/ready with request kind and raw converter word.
// ----------------------------------------------------------------------------
interface bcu_req_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [bcu_pkg::RAW_W-1:0]     raw_sample;

	modport source (output valid, output req_type, output raw_sample, input ready);
	modport sink   (input valid, input req_type, input raw_sample, output ready);
endinterface

// ===== rtl/bcu_res_if.sv =====
// ----------------------------------------------------------------------------
// bcu_res_if
// Result channel: valid/ready with the compensated reading.
// ----------------------------------------------------------------------------
interface bcu_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [bcu_pkg::VAL_W-1:0]  measured_value;
	logic                              value_kind;
	logic                              divide_fault;

	modport source (output valid, output measured_value, output value_kind,
		output divide_fault, input ready);
	modport sink   (input valid, input measured_value, input value_kind,
		input divide_fault, output ready);
endinterface

// ===== rtl/barometer_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// barometer_compensation_unit
// Integer temperature and pressure compensation on one shared multiplier
// and one shared radix-2 divider under a micro-step sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, raw_sample
//  res      out  valid/ready    measured_value, value_kind, divide_fault
//  cfg      in   cfg_we         cfg_index, cfg_data
//
//  Temperature item: accept, 4 steps, a divide and the finish cycle
//  (straight to finish from the divide step on a zero divisor).
//  Pressure item: accept, 18 steps, two divides and the finish cycle
//  (straight to finish when B4 is zero).
//  The divider is bit-serial; one item is in work at a time.
//  The result register lets a new item start while the last result waits;
//  a result that is still held stalls the finish cycle.
//  arst_n clears control state, the stored raw temperature and the config registers.
// ----------------------------------------------------------------------------
module barometer_compensation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcu_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bcu_pkg::CFG_W-1:0]     cfg_data,
	bcu_req_if.sink                       req,
	bcu_res_if.source                     res
);

	bcu_pkg::state_t state_q;
	bcu_pkg::step_t  step_q;

	logic [bcu_pkg::OSS_W-1:0]  oss_q;
	logic [bcu_pkg::CGA_W-1:0]  cga_q;
	logic [bcu_pkg::CGB_W-1:0]  cgb_q;
	logic [bcu_pkg::CGC_W-1:0]  cgc_q;
	logic [bcu_pkg::TEMP_W-1:0] ut_q;
	logic [bcu_pkg::RAW_W-1:0]  raw_q;
	logic                       kind_q;

	logic [31:0] prod_q, acc_q, x1_q, b3_q, b4_q, b6_q, sq_q, p_q, res_q;
	logic        fault_q, neg_q, dbl_q;

	logic [31:0] rem_q, quo_q, den_q;
	logic [bcu_pkg::CNT_W-1:0] cnt_q;

	logic        out_valid_q, out_kind_q, out_fault_q;
	logic [31:0] out_value_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_full;
	logic [32:0] div_r;
	logic        div_ge;
	logic [31:0] d_t, num_t, x2_t, b5_t, t_b3, v_b3, s_x3, up_t, q_t, s_res, psh;
	logic [15:0] scale_t;

	assign ac1 = {{16{cga_q[15]}}, cga_q[15:0]};
	assign ac2 = {{16{cga_q[31]}}, cga_q[31:16]};
	assign ac3 = {{16{cga_q[47]}}, cga_q[47:32]};
	assign ac4 = {16'b0, cga_q[63:48]};
	assign ac5 = {16'b0, cgb_q[15:0]};
	assign ac6 = {16'b0, cgb_q[31:16]};
	assign b1  = {{16{cgb_q[47]}}, cgb_q[47:32]};
	assign b2  = {{16{cgb_q[63]}}, cgb_q[63:48]};
	assign mc  = {{16{cgc_q[31]}}, cgc_q[31:16]};
	assign md  = {{16{cgc_q[47]}}, cgc_q[47:32]};

	// datapath terms
	assign d_t     = x1_q + md;
	assign num_t   = mc << 11;
	assign x2_t    = neg_q ? (32'd0 - quo_q) : quo_q;
	assign b5_t    = x1_q + x2_t;
	assign t_b3    = (ac1 << 2) + acc_q;
	assign v_b3    = (t_b3 << oss_q) + 32'd2;
	assign s_x3    = acc_q + $unsigned($signed(prod_q) >>> 16) + 32'd2;
	assign up_t    = {8'b0, raw_q >> (4'd8 - {2'b0, oss_q})};
	assign scale_t = bcu_pkg::PRESS_SCALE >> oss_q;
	assign q_t     = dbl_q ? {quo_q[30:0], 1'b0} : quo_q;
	assign s_res   = acc_q + $unsigned($signed(prod_q) >>> 16) + bcu_pkg::CORR_C;
	assign psh     = $unsigned($signed(p_q) >>> 8);

	// shared multiplier operand select
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (step_q)
			bcu_pkg::SP_T_MUL: begin
				mul_a = {16'b0, ut_q} - ac6;
				mul_b = ac5;
			end
			bcu_pkg::SP_B6SQ: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			bcu_pkg::SP_SQ: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			bcu_pkg::SP_AC2: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			bcu_pkg::SP_X3A: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			bcu_pkg::SP_B3: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			bcu_pkg::SP_B4MUL: begin
				mul_a = ac4;
				mul_b = acc_q + bcu_pkg::PRESS_BIAS;
			end
			bcu_pkg::SP_B4: begin
				mul_a = up_t - b3_q;
				mul_b = {16'b0, scale_t};
			end
			bcu_pkg::SP_PSQ: begin
				mul_a = psh;
				mul_b = psh;
			end
			bcu_pkg::SP_CA: begin
				mul_a = prod_q;
				mul_b = bcu_pkg::CORR_A;
			end
			bcu_pkg::SP_CB: begin
				mul_a = bcu_pkg::CORR_B;
				mul_b = p_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign div_r    = {rem_q, quo_q[31]};
	assign div_ge   = div_r >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q <= '0;
			cga_q <= '0;
			cgb_q <= '0;
			cgc_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bcu_pkg::REG_OSS: oss_q <= cfg_data[bcu_pkg::OSS_W-1:0];
				bcu_pkg::REG_CGA: cga_q <= cfg_data[bcu_pkg::CGA_W-1:0];
				bcu_pkg::REG_CGB: cgb_q <= cfg_data[bcu_pkg::CGB_W-1:0];
				bcu_pkg::REG_CGC: cgc_q <= cfg_data[bcu_pkg::CGC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcu_pkg::ST_IDLE;
			step_q      <= bcu_pkg::SP_T_MUL;
			ut_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the finish state reloads the result register itself
			if (out_valid_q && res.ready && state_q != bcu_pkg::ST_FIN)
				out_valid_q <= 1'b0;
			case (state_q)
				bcu_pkg::ST_IDLE: begin
					if (req.valid) begin
						kind_q  <= req.req_type;
						raw_q   <= req.raw_sample;
						if (req.req_type == bcu_pkg::KIND_TEMP)
							ut_q <= req.raw_sample[bcu_pkg::TEMP_W-1:0];
						fault_q <= 1'b0;
						step_q  <= bcu_pkg::SP_T_MUL;
						state_q <= bcu_pkg::ST_CALC;
					end
				end
				bcu_pkg::ST_CALC: begin
					prod_q <= mul_full[31:0];
					step_q <= bcu_pkg::step_t'(step_q + 5'd1);
					case (step_q)
						bcu_pkg::SP_T_X1:
							x1_q <= $unsigned($signed(prod_q) >>> 15);
						bcu_pkg::SP_T_DIV: begin
							if (d_t == 32'd0) begin
								fault_q <= 1'b1;
								res_q   <= 32'd0;
								state_q <= bcu_pkg::ST_FIN;
							end else begin
								neg_q   <= num_t[31] ^ d_t[31];
								rem_q   <= 32'd0;
								quo_q   <= num_t[31] ? (32'd0 - num_t) : num_t;
								den_q   <= d_t[31] ? (32'd0 - d_t) : d_t;
								cnt_q   <= '1;
								state_q <= bcu_pkg::ST_DIV;
							end
						end
						bcu_pkg::SP_B5: begin
							if (kind_q == bcu_pkg::KIND_TEMP) begin
								res_q   <= $unsigned($signed(b5_t + 32'd8) >>> 4);
								state_q <= bcu_pkg::ST_FIN;
							end
							b6_q <= b5_t - bcu_pkg::PRESS_OFFSET_T;
						end
						bcu_pkg::SP_SQ:
							sq_q <= $unsigned($signed(prod_q) >>> 12);
						bcu_pkg::SP_AC2:
							acc_q <= $unsigned($signed(prod_q) >>> 11);
						bcu_pkg::SP_X3A:
							acc_q <= acc_q + $unsigned($signed(prod_q) >>> 11);
						bcu_pkg::SP_B3: begin
							// divide by four, truncating toward zero
							b3_q  <= v_b3[31] ? $unsigned($signed(v_b3 + 32'd3) >>> 2)
								: $unsigned($signed(v_b3) >>> 2);
							acc_q <= $unsigned($signed(prod_q) >>> 13);
						end
						bcu_pkg::SP_X3B:
							acc_q <= $unsigned($signed(s_x3) >>> 2);
						bcu_pkg::SP_B4: begin
							b4_q <= {15'b0, prod_q[31:15]};
							if (prod_q[31:15] == 17'd0) begin
								fault_q <= 1'b1;
								res_q   <= 32'd0;
								state_q <= bcu_pkg::ST_FIN;
							end
						end
						bcu_pkg::SP_P_DIV: begin
							dbl_q   <= prod_q[31];
							rem_q   <= 32'd0;
							quo_q   <= prod_q[31] ? prod_q : {prod_q[30:0], 1'b0};
							den_q   <= b4_q;
							cnt_q   <= '1;
							state_q <= bcu_pkg::ST_DIV;
						end
						bcu_pkg::SP_P:
							p_q <= q_t;
						bcu_pkg::SP_CB:
							acc_q <= $unsigned($signed(prod_q) >>> 16);
						bcu_pkg::SP_RES: begin
							res_q   <= p_q + $unsigned($signed(s_res) >>> 4);
							state_q <= bcu_pkg::ST_FIN;
						end
						default: ;
					endcase
				end
				bcu_pkg::ST_DIV: begin
					// one quotient bit per cycle
					if (div_ge) begin
						rem_q <= 32'(div_r - {1'b0, den_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= div_r[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= bcu_pkg::ST_CALC;
				end
				bcu_pkg::ST_FIN: begin
					// hold until the result register is free
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_kind_q  <= kind_q;
						out_fault_q <= fault_q;
						state_q     <= bcu_pkg::ST_IDLE;
					end
				end
				default: state_q <= bcu_pkg::ST_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == bcu_pkg::ST_IDLE);
	assign res.valid          = out_valid_q;
	assign res.measured_value = $signed(out_value_q);
	assign res.value_kind     = out_kind_q;
	assign res.divide_fault   = out_fault_q;

endmodule

// ===== sim/bcu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcu_checker
// Watches the config port and both channels, predicts each compensated
// reading from the raw item and the shadow registers, and compares results.
// ----------------------------------------------------------------------------
module bcu_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bcu_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bcu_pkg::CFG_W-1:0]     cfg_data,
	bcu_req_if                            req,
	bcu_res_if                            res,
	output int                            fail_count,
	output int                            pending
);

	typedef struct packed {
		logic signed [bcu_pkg::VAL_W-1:0] value;
		logic                             kind;
		logic                             fault;
	} reading_t;

	reading_t                      readings[$];
	logic [bcu_pkg::OSS_W-1:0]     oss_sh;
	logic [bcu_pkg::CGA_W-1:0]     cga_sh;
	logic [bcu_pkg::CGB_W-1:0]     cgb_sh;
	logic [bcu_pkg::CGC_W-1:0]     cgc_sh;
	logic [bcu_pkg::TEMP_W-1:0]    raw_temp_sh;

	function automatic int w32(longint x);
		return int'(x[31:0]);
	endfunction

	function automatic longint sf(logic [63:0] r, int pos);
		return longint'(shortint'(r[pos+:16]));
	endfunction

	function automatic longint uf(logic [63:0] r, int pos);
		return longint'({48'd0, r[pos+:16]});
	endfunction

	// true divisor of the temperature formula is x1 + md
	function automatic bit calc_b5(input logic [15:0] ut, output int b5);
		longint ac5, ac6, mc, md, x1, d, x2;
		ac5 = uf(cgb_sh, 0);
		ac6 = uf(cgb_sh, 16);
		mc  = sf({16'd0, cgc_sh}, 16);
		md  = sf({16'd0, cgc_sh}, 32);
		x1  = w32((longint'(ut) - ac6) * ac5) >>> 15;
		d   = w32(x1 + md);
		if (d == 0)
			return 0;
		x2 = w32((mc * 2048) / d);
		b5 = w32(x1 + x2);
		return 1;
	endfunction

	function automatic bit calc_pressure(input logic [23:0] raw, output int res_v);
		longint ac1, ac2, ac3, b1, b2, b6, sq, x1, x2, x3, b3, p;
		logic [63:0] ac4, t64;
		logic [31:0] up, b4, b7, q;
		int b5;
		int unsigned oss;
		oss = oss_sh;
		ac1 = sf(cga_sh, 0);
		ac2 = sf(cga_sh, 16);
		ac3 = sf(cga_sh, 32);
		ac4 = uf(cga_sh, 48);
		b1  = sf(cgb_sh, 32);
		b2  = sf(cgb_sh, 48);
		if (!calc_b5(raw_temp_sh, b5))
			return 0;
		b6 = w32(longint'(b5) - 4000);
		sq = w32(b6 * b6) >>> 12;
		x1 = w32(b2 * sq) >>> 11;
		x2 = w32(ac2 * b6) >>> 11;
		x3 = w32(x1 + x2);
		b3 = w32(longint'(w32(w32(ac1 * 4 + x3) * (longint'(1) << oss))) + 2);
		b3 = int'(b3) / 4;
		x1 = w32(ac3 * b6) >>> 13;
		x2 = w32(b1 * sq) >>> 16;
		x3 = w32(x1 + x2 + 2) >>> 2;
		t64 = 64'(x3 + 32768);
		t64 = ac4 * {32'd0, t64[31:0]};
		b4 = t64[31:0] >> 15;
		if (b4 == 0)
			return 0;
		up = {8'd0, raw} >> (8 - oss);
		t64 = {32'd0, up - b3[31:0]} * 64'(50000 >> oss);
		b7 = t64[31:0];
		if (b7 < 32'h8000_0000) begin
			t64 = ({32'd0, b7} * 2) / {32'd0, b4};
			q = t64[31:0];
		end else begin
			q = (b7 / b4) * 2;
		end
		p = int'(q);
		x1 = w32((p >>> 8) * (p >>> 8));
		x1 = w32(x1 * 3038) >>> 16;
		x2 = w32(-7357 * p) >>> 16;
		res_v = w32(p + (w32(x1 + x2 + 3791) >>> 4));
		return 1;
	endfunction

	function automatic reading_t compensate(logic kind, logic [bcu_pkg::RAW_W-1:0] raw);
		reading_t r;
		int v, b5;
		bit ok;
		v = 0;
		if (kind == bcu_pkg::KIND_TEMP) begin
			raw_temp_sh = raw[bcu_pkg::TEMP_W-1:0];
			ok = calc_b5(raw_temp_sh, b5);
			if (ok)
				v = w32(longint'(b5) + 8) >>> 4;
		end else begin
			ok = calc_pressure(raw, v);
		end
		r.value = ok ? v : 0;
		r.kind  = kind;
		r.fault = !ok;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			oss_sh      <= '0;
			cga_sh      <= '0;
			cgb_sh      <= '0;
			cgc_sh      <= '0;
			raw_temp_sh = '0;
			readings.delete();
			fail_count  <= 0;
			pending     <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bcu_pkg::REG_OSS: oss_sh <= cfg_data[bcu_pkg::OSS_W-1:0];
					bcu_pkg::REG_CGA: cga_sh <= cfg_data;
					bcu_pkg::REG_CGB: cgb_sh <= cfg_data;
					bcu_pkg::REG_CGC: cgc_sh <= cfg_data[bcu_pkg::CGC_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				readings.push_back(compensate(req.req_type, req.raw_sample));
			if (res.valid && res.ready) begin
				if (readings.size() == 0) begin
					$error("unexpected result value=%0d kind=%0b fault=%0b",
						res.measured_value, res.value_kind, res.divide_fault);
					errs++;
				end else begin
					e = readings.pop_front();
					if (res.measured_value !== e.value) begin
						$error("measured_value expected %0d actual %0d",
							e.value, res.measured_value);
						errs++;
					end
					if (res.value_kind !== e.kind) begin
						$error("value_kind expected %0b actual %0b", e.kind, res.value_kind);
						errs++;
					end
					if (res.divide_fault !== e.fault) begin
						$error("divide_fault expected %0b actual %0b",
							e.fault, res.divide_fault);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= readings.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raw temperature and pressure items and coefficient settings into
// the compensation unit under varied idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WATCHDOG = 20000;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bcu_pkg::IDX_W-1:0]     cfg_index;
	logic [bcu_pkg::CFG_W-1:0]     cfg_data;
	int                            fail_count;
	int                            pending;
	int                            send_idle;
	int                            recv_stall;
	int                            quiet;

	bcu_req_if req_ch ();
	bcu_res_if res_ch ();

	barometer_compensation_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.res       (res_ch)
	);

	bcu_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req        (req_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			res_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// abort when nothing moves on either channel for too long
	initial begin
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG) begin
				$display("barometer_compensation_unit: mismatch");
				$finish;
			end
		end
	end

	// leaves valid high so a following item can go out back to back
	task automatic send_item(logic kind, logic [bcu_pkg::RAW_W-1:0] raw);
		while ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.raw_sample <= raw;
		do @(negedge clk); while (!req_ch.ready);
		@(posedge clk);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [bcu_pkg::IDX_W-1:0] idx,
			logic [bcu_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_coeffs(logic [1:0] oss, logic [63:0] a, logic [63:0] b,
			logic [47:0] c);
		write_reg(bcu_pkg::REG_OSS, {62'd0, oss});
		write_reg(bcu_pkg::REG_CGA, a);
		write_reg(bcu_pkg::REG_CGB, b);
		write_reg(bcu_pkg::REG_CGC, {16'd0, c});
	endtask

	// typical calibration words
	localparam logic [63:0] CAL_A = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
	localparam logic [63:0] CAL_B = {16'd4, 16'd6190, 16'd23153, 16'd32757};
	localparam logic [47:0] CAL_C = {16'd2868, 16'hDDE9, 16'h8000};

	function automatic logic [15:0] jitter(logic [15:0] w);
		return w + 16'($urandom_range(64)) - 16'd32;
	endfunction

	initial begin
		logic [63:0] a, b;
		logic [47:0] c;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = bcu_pkg::KIND_TEMP;
		req_ch.raw_sample = '0;
		send_idle         = 0;
		recv_stall        = 0;
		arst_n            = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: every divisor is zero, pressure before temperature
		send_item(bcu_pkg::KIND_PRESS, 24'hFFFFFF);
		send_item(bcu_pkg::KIND_TEMP, 24'h00FFFF);
		send_item(bcu_pkg::KIND_PRESS, 24'h000000);
		drain();

		load_coeffs(2'd0, CAL_A, CAL_B, CAL_C);
		send_item(bcu_pkg::KIND_PRESS, 24'h5D2300);
		send_item(bcu_pkg::KIND_TEMP, 24'h006CFA);
		send_item(bcu_pkg::KIND_PRESS, 24'h5D2300);
		send_item(bcu_pkg::KIND_TEMP, 24'hFF0000);
		send_item(bcu_pkg::KIND_PRESS, 24'hFFFFFF);
		send_item(bcu_pkg::KIND_TEMP, 24'h00FFFF);
		send_item(bcu_pkg::KIND_PRESS, 24'h000000);
		send_item(bcu_pkg::KIND_PRESS, 24'hFFFFFF);
		drain();

		// zero pressure divisor, then zero temperature divisor, widest shift
		load_coeffs(2'd3, {16'd0, CAL_A[47:0]}, CAL_B, CAL_C);
		send_item(bcu_pkg::KIND_TEMP, 24'h006CFA);
		send_item(bcu_pkg::KIND_PRESS, 24'hABCDEF);
		drain();
		load_coeffs(2'd3, CAL_A, {CAL_B[63:16], 16'd0}, {16'd0, CAL_C[31:0]});
		send_item(bcu_pkg::KIND_TEMP, 24'h123456);
		send_item(bcu_pkg::KIND_PRESS, 24'h654321);
		drain();

		load_coeffs(2'd2, '1, '1, '1);
		send_item(bcu_pkg::KIND_TEMP, 24'h000000);
		send_item(bcu_pkg::KIND_PRESS, 24'hFFFFFF);
		send_item(bcu_pkg::KIND_TEMP, 24'hFFFFFF);
		send_item(bcu_pkg::KIND_PRESS, 24'h800000);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 65; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 65; end
				default: begin send_idle = 28; recv_stall = 28; end
			endcase
			if (ph == 6) begin
				a = {$urandom, $urandom};
				b = {$urandom, $urandom};
				c = 48'({$urandom, $urandom});
			end else if (ph == 7) begin
				a = '1;
				b = '1;
				c = '1;
			end else begin
				a = {jitter(CAL_A[63:48]), jitter(CAL_A[47:32]),
					jitter(CAL_A[31:16]), jitter(CAL_A[15:0])};
				b = {jitter(CAL_B[63:48]), jitter(CAL_B[47:32]),
					jitter(CAL_B[31:16]), jitter(CAL_B[15:0])};
				c = {jitter(CAL_C[47:32]), jitter(CAL_C[31:16]), 16'($urandom)};
			end
			load_coeffs(2'(ph), a, b, c);
			for (int n = 0; n < 62; n++) begin
				if ($urandom_range(99) < 40) begin
					if ($urandom_range(3) == 0)
						send_item(bcu_pkg::KIND_TEMP, 24'($urandom));
					else
						send_item(bcu_pkg::KIND_TEMP, {8'($urandom),
							16'($urandom_range(32000, 22000))});
				end else begin
					if ($urandom_range(3) == 0)
						send_item(bcu_pkg::KIND_PRESS, 24'($urandom));
					else
						send_item(bcu_pkg::KIND_PRESS,
							24'($urandom_range(24'h6A0000, 24'h4C0000)));
				end
				if ($urandom_range(15) == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(40)) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("barometer_compensation_unit: match");
		else
			$display("barometer_compensation_unit: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bcu_pkg.sv
rtl/bcu_req_if.sv
rtl/bcu_res_if.sv
rtl/barometer_compensation_unit.sv
sim/bcu_checker.sv
sim/tb_top.sv
